// File: hdl/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
// No dependencies; imported by every module in hdl/.
package bra_pkg;

    localparam int MAP_BYTES = 128;
    localparam int BYTE_W    = 8;
    localparam int BIT_W     = 3;
    localparam int MODE_W    = 2;
    localparam int IDX_W     = 10;
    localparam int RUN_W     = 11;
    localparam int CFG_W     = 8;
    localparam int CFG_RESET = 128;

    localparam int BYTE_AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNT_W   = $clog2(MAP_BYTES + 1);
    localparam int CW_A    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    // byte-count width: holds the map size, the config value and an index's byte part
    localparam int CW      = (CW_A > IDX_W - BIT_W) ? CW_A : IDX_W - BIT_W;
    localparam int PW      = CW + BIT_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_TEST  = 2'd0,
        MODE_SCAN  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef struct packed {
        logic               en;
        logic [BYTE_AW-1:0] addr;
        logic [BYTE_W-1:0]  data;
    } t_map_wr;

endpackage

// File: hdl/bra_map.sv
// Occupancy bitmap store: one byte per row, registered read, one write port.
// Depends on bra_pkg. Per-row valid bits make unwritten rows read as free.
module bra_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bra_pkg::BYTE_AW-1:0]   i_rd_addr,
    output logic [bra_pkg::BYTE_W-1:0]    o_rd_data,
    input  bra_pkg::t_map_wr              i_wr
);
    import bra_pkg::*;

    logic [BYTE_W-1:0]    r_mem [MAP_BYTES];
    logic [MAP_BYTES-1:0] r_vld;
    logic [BYTE_W-1:0]    r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/bra_run_step.sv
// Scan datapath: advances the free-run counter across one bitmap byte.
// Depends on bra_pkg. Reports the first bit at which the run reaches the target.
module bra_run_step (
    input  logic [bra_pkg::BYTE_W-1:0] i_byte,
    input  logic [bra_pkg::RUN_W-1:0]  i_run,
    input  logic [bra_pkg::RUN_W-1:0]  i_need,
    output logic [bra_pkg::RUN_W-1:0]  o_run,
    output logic                       o_hit,
    output logic [bra_pkg::BIT_W-1:0]  o_bit
);
    import bra_pkg::*;

    // Run at bit i is either the incoming run plus i+1 (no set bit so far in this
    // byte) or the short local count of free bits since the last set bit.
    always_comb begin
        logic [BIT_W:0]   local_run;
        logic             all_free;
        logic [RUN_W-1:0] run;
        local_run = '0;
        all_free  = 1'b1;
        run       = i_run;
        o_hit     = 1'b0;
        o_bit     = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (i_byte[i]) begin
                local_run = '0;
                all_free  = 1'b0;
            end else begin
                local_run = local_run + (BIT_W+1)'(1);
            end
            run = all_free ? (i_run + RUN_W'(i + 1)) : RUN_W'(local_run);
            if (!o_hit && run == i_need) begin
                o_hit = 1'b1;
                o_bit = BIT_W'(i);
            end
        end
        o_run = run;
    end

endmodule

// File: hdl/bitmap_run_allocator_top.sv
// Top level of the bitmap run allocator: sequencer, config register, result register.
// Depends on bra_pkg, bra_map and bra_run_step.
//
//  channel | direction | handshake                | payload
//  in      | into      | i_in_valid / o_in_stall  | mode, bit_index, run_length, write_value
//  out     | out of    | o_out_valid / i_out_stall| bit_is_set, found, start_index
//  cfg     | into      | i_cfg_valid / o_cfg_ready| bytes_in_use
//
// Test and write pass through S_BIT and S_DONE to the result register; one beat at a time.
// A scan reads one bitmap byte per cycle from the single read port, up to bytes_in_use bytes
// (capped at the 128-byte map), fewer when a run is found early.
// Reset is synchronous, active low; the map reads all free after reset with no clearing pass.
// The input is stalled while an item is in progress; the result register frees the
// sequencer as soon as the previous beat has been taken.
module bitmap_run_allocator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bra_pkg::MODE_W-1:0]   i_mode,
    input  logic [bra_pkg::IDX_W-1:0]    i_bit_index,
    input  logic [bra_pkg::RUN_W-1:0]    i_run_length,
    input  logic                         i_write_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_bit_is_set,
    output logic                         o_found,
    output logic [bra_pkg::IDX_W-1:0]    o_start_index,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bra_pkg::CFG_W-1:0]    i_cfg_bytes_in_use
);
    import bra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_BIT  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cfg;
    t_mode              r_mode;
    logic [IDX_W-1:0]   r_idx;
    logic [RUN_W-1:0]   r_need;
    logic               r_val;
    logic               r_in_rng;
    logic [CW-1:0]      r_rd, n_rd;
    logic [CW-1:0]      r_proc, n_proc;
    logic               r_pend, n_pend;
    logic [RUN_W-1:0]   r_run, n_run;
    logic               r_res_set, n_res_set;
    logic               r_res_found, n_res_found;
    logic [IDX_W-1:0]   r_res_start, n_res_start;
    logic               r_out_vld;
    logic               r_out_set;
    logic               r_out_found;
    logic [IDX_W-1:0]   r_out_start;

    logic [CW-1:0]      eff_bytes;
    logic [CW-1:0]      in_byte;
    logic               in_acc;
    logic               out_load;
    logic [BYTE_AW-1:0] rd_addr;
    logic [BYTE_W-1:0]  rd_data;
    t_map_wr            map_wr;
    logic [BYTE_W-1:0]  wr_byte;
    logic [RUN_W-1:0]   step_run;
    logic               step_hit;
    logic [BIT_W-1:0]   step_bit;
    logic [PW-1:0]      hit_start;

    bra_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (map_wr)
    );

    bra_run_step u_step (
        .i_byte (rd_data),
        .i_run  (r_run),
        .i_need (r_need),
        .o_run  (step_run),
        .o_hit  (step_hit),
        .o_bit  (step_bit)
    );

    // saturate the configured length to the store size
    assign eff_bytes = (CW'(r_cfg) > CW'(MAP_BYTES)) ? CW'(MAP_BYTES) : CW'(r_cfg);
    assign in_byte   = CW'(i_bit_index[IDX_W-1:BIT_W]);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_load  = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);
    assign hit_start = PW'({r_proc, step_bit}) + PW'(1) - PW'(r_need);

    always_comb begin
        wr_byte             = rd_data;
        wr_byte[r_idx[BIT_W-1:0]] = r_val;
        map_wr.en   = (r_state == S_BIT) && (r_mode == MODE_WRITE) && r_in_rng;
        map_wr.addr = BYTE_AW'(r_idx[IDX_W-1:BIT_W]);
        map_wr.data = wr_byte;
    end

    always_comb begin
        priority if (r_state == S_IDLE) begin
            rd_addr = in_byte[BYTE_AW-1:0];
        end else if (r_state == S_SCAN) begin
            rd_addr = r_rd[BYTE_AW-1:0];
        end else begin
            rd_addr = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rd        = r_rd;
        n_proc      = r_proc;
        n_pend      = 1'b0;
        n_run       = r_run;
        n_res_set   = r_res_set;
        n_res_found = r_res_found;
        n_res_start = r_res_start;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_set   = 1'b0;
                    n_res_found = 1'b0;
                    n_res_start = '0;
                    n_rd        = '0;
                    n_proc      = '0;
                    n_run       = '0;
                    unique case (t_mode'(i_mode))
                        MODE_TEST, MODE_WRITE: begin
                            n_state = S_BIT;
                        end
                        MODE_SCAN: begin
                            if (i_run_length == '0 || eff_bytes == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_BIT: begin
                if (r_mode == MODE_TEST) begin
                    n_res_set = r_in_rng && rd_data[r_idx[BIT_W-1:0]];
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                // read one byte ahead of the byte being processed
                if (r_rd < eff_bytes) begin
                    n_rd   = r_rd + CW'(1);
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    n_run = step_run;
                    if (step_hit) begin
                        n_res_found = 1'b1;
                        n_res_start = hit_start[IDX_W-1:0];
                        n_state     = S_DONE;
                        n_pend      = 1'b0;
                    end else if (r_proc == eff_bytes - CW'(1)) begin
                        n_state = S_DONE;
                        n_pend  = 1'b0;
                    end else begin
                        n_proc = r_proc + CW'(1);
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= CFG_W'(CFG_RESET);
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_bytes_in_use;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode   <= t_mode'(i_mode);
            r_idx    <= i_bit_index;
            r_need   <= i_run_length;
            r_val    <= i_write_value;
            r_in_rng <= in_byte < eff_bytes;
        end
        r_rd        <= n_rd;
        r_proc      <= n_proc;
        r_run       <= n_run;
        r_res_set   <= n_res_set;
        r_res_found <= n_res_found;
        r_res_start <= n_res_start;
        if (out_load) begin
            r_out_set   <= r_res_set;
            r_out_found <= r_res_found;
            r_out_start <= r_res_start;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_vld;
    assign o_bit_is_set  = r_out_set;
    assign o_found       = r_out_found;
    assign o_start_index = r_out_start;

    a_found_xor_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_bit_is_set))
        else $error("scan and test result both set");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_start_index == '0))
        else $error("start index nonzero without a found run");

    a_wr_only_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_wr.en |-> (r_state == S_BIT))
        else $error("bitmap written outside the bit step");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_vld && i_out_stall) |=> (r_state == S_DONE))
        else $error("result dropped while output register full");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_proc < eff_bytes))
        else $error("scan past the configured end");

endmodule
